// ===== src/access_window_table_manager_assert.svh =====
// Assertion macros shared by the access window table checker.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef ACCESS_WINDOW_TABLE_MANAGER_ASSERT_SVH
`define ACCESS_WINDOW_TABLE_MANAGER_ASSERT_SVH

// Implication checked on every rising edge outside reset.
`define AWTM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("access window table assertion failed");

// A signal holds while a request is stalled.
`define AWTM_ASSERT_HOLD(label, stall, sig) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (stall) |=> $stable(sig)) else $error("access window table hold violated");

`endif

// ===== src/awtm_pkg.sv =====
// Types and constants of the access window table manager.
// No dependencies; used by the cell and the top level.
`timescale 1ns / 1ps

package awtm_pkg;

  localparam int SlotW   = 4;
  localparam int CountW  = SlotW + 1;
  localparam int BaseW   = 20;
  localparam int TargetW = 8;
  localparam int CodeW   = 5;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_SPACE  = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic {
    KIND_ENABLE  = 1'b0,
    KIND_DISABLE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // Window contents that a request compares against (enable bit implied).
  typedef struct packed {
    logic [BaseW-1:0]   base;
    logic [TargetW-1:0] target;
    logic [CodeW-1:0]   code;
  } key_t;

  // Search token passed from cell to cell.
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [SlotW-1:0] hit_slot;
    logic             free;
    logic [SlotW-1:0] free_slot;
  } token_t;

  // Broadcast write into one cell.
  typedef struct packed {
    logic             en;
    logic             clear;
    logic [SlotW-1:0] slot;
  } wr_t;

endpackage

// ===== src/awtm_cell.sv =====
// One access window: stored base and attributes plus one stage of the search chain.
// Depends on awtm_pkg.
`timescale 1ns / 1ps

module awtm_cell import awtm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SlotW-1:0]  idx_i,
  input  logic [CountW-1:0] count_i,
  input  key_t              key_i,
  input  wr_t               wr_i,
  input  token_t            tok_i,
  output token_t            tok_o
);

  logic               en_q;
  key_t               win_q;
  token_t             tok_q;
  logic               active;
  logic               hit_here;
  logic               free_here;
  token_t             tok_d;

  assign active    = {1'b0, idx_i} < count_i;
  assign hit_here  = active && en_q && (win_q == key_i);
  assign free_here = active && !en_q;

  always_comb begin
    tok_d           = tok_i;
    tok_d.hit       = tok_i.hit | hit_here;
    tok_d.hit_slot  = tok_i.hit ? tok_i.hit_slot : idx_i;
    tok_d.free      = tok_i.free | free_here;
    tok_d.free_slot = tok_i.free ? tok_i.free_slot : idx_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= 1'b0;
      win_q <= '0;
    end else if (wr_i.en && (wr_i.slot == idx_i)) begin
      if (wr_i.clear) begin
        en_q  <= 1'b0;
        win_q <= '0;
      end else begin
        en_q  <= 1'b1;
        win_q <= key_i;
      end
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== src/access_window_table_manager.sv =====
// Flow: the accepted request's key is registered, then the search token walks one window cell
// per cycle; the token leaving the last cell is latched, and the finish state decides, writes
// and registers the result, waiting while an earlier result is still stalled on the output.
// Requests: one at a time; a new request is accepted only once the previous one has finished.
// Reset: asynchronous, active low; all windows cleared and disabled, window count 8.
// Depends on awtm_pkg and awtm_cell.
`timescale 1ns / 1ps

module access_window_table_manager import awtm_pkg::*; #(
  parameter int MAX_WINDOWS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config: window_count
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i,
  // request
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // target[7:0], base_address[39:8], window_size[71:40]
  input  logic        s_axis_tuser_i,   // kind
  // result
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // status[1:0], slot[5:2], zero[7:6]
);

  state_e            state_q, state_d;
  logic [3:0]        wcount_q;
  logic [CountW-1:0] count;
  key_t              key_q;
  kind_e             kind_q;
  logic              start_q;
  token_t            fin_q, fin_d;
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic              accept;
  wr_t               wr;
  token_t            tok [MAX_WINDOWS+1];
  key_t              key_new;
  logic [31:0]       size;
  logic [31:0]       lsb;
  logic [CodeW-1:0]  pos;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcount_q <= 4'd8;
    end else if (cfg_valid_i) begin
      wcount_q <= cfg_data_i;
    end
  end

  assign count = ({1'b0, wcount_q} > CountW'(MAX_WINDOWS)) ? CountW'(MAX_WINDOWS)
                                                           : {1'b0, wcount_q};

  // size code: index of lowest set bit minus one, saturated at zero
  assign size = s_axis_tdata_i[71:40];
  assign lsb  = size & (~size + 32'd1);
  always_comb begin
    pos = '0;
    for (int b = 0; b < 32; b++) begin
      if (lsb[b]) pos = pos | CodeW'(b);
    end
  end

  assign key_new.base   = s_axis_tdata_i[39:20];
  assign key_new.target = s_axis_tdata_i[7:0];
  assign key_new.code   = (pos == '0) ? '0 : pos - CodeW'(1);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q  <= key_new;
      kind_q <= kind_e'(s_axis_tuser_i);
    end
  end

  // token enters the chain once the request key is registered
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = start_q;
  end

  for (genvar i = 0; i < MAX_WINDOWS; i++) begin : g_cell
    awtm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (SlotW'(i)),
      .count_i (count),
      .key_i   (key_q),
      .wr_i    (wr),
      .tok_i   (tok[i]),
      .tok_o   (tok[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      start_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      start_q     <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q    <= fin_d;
    status_q <= status_d;
    slot_q   <= slot_d;
  end

  always_comb begin
    state_d     = state_q;
    fin_d       = fin_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    status_d    = status_q;
    slot_d      = slot_q;
    wr          = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (tok[MAX_WINDOWS].valid) begin
          fin_d   = tok[MAX_WINDOWS];
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          status_d    = STATUS_OK;
          slot_d      = fin_q.hit_slot;
          if (kind_q == KIND_ENABLE) begin
            if (!fin_q.hit) begin
              if (fin_q.free) begin
                wr.en    = 1'b1;
                wr.slot  = fin_q.free_slot;
                slot_d   = fin_q.free_slot;
              end else begin
                status_d = STATUS_NO_SPACE;
                slot_d   = '0;
              end
            end
          end else begin
            if (fin_q.hit) begin
              wr.en    = 1'b1;
              wr.clear = 1'b1;
              wr.slot  = fin_q.hit_slot;
            end else begin
              status_d = STATUS_NOT_FOUND;
              slot_d   = '0;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, slot_q, status_q};

endmodule

// ===== src/awtm_checker.sv =====
// Port-level checker for the access window table manager, bound to the top level.
// Depends on access_window_table_manager_assert.svh.
`timescale 1ns / 1ps
`include "access_window_table_manager_assert.svh"

module awtm_checker #(
  parameter int MAX_WINDOWS = 12
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o
);

  logic out_stall;
  logic in_accept;
  logic out_err;

  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_err   = m_axis_tvalid_o && (m_axis_tdata_o[1:0] != 2'd0);

  `AWTM_ASSERT_HOLD(a_result_held, out_stall, m_axis_tdata_o)
  // one request at a time: the input side closes right after a request
  `AWTM_ASSERT(a_one_in_flight, in_accept |=> !s_axis_tready_o)
  `AWTM_ASSERT(a_status_code, m_axis_tvalid_o |-> (m_axis_tdata_o[1:0] != 2'd3))
  `AWTM_ASSERT(a_err_slot_zero, out_err |-> (m_axis_tdata_o[5:2] == 4'd0))
  `AWTM_ASSERT(a_slot_range,
    m_axis_tvalid_o |-> (32'(m_axis_tdata_o[5:2]) < MAX_WINDOWS))

endmodule

bind access_window_table_manager awtm_checker #(
  .MAX_WINDOWS (MAX_WINDOWS)
) u_awtm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
